>>> design/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DepthDefault     = 16;
   localparam int DataWidthDefault = 32;

   localparam int ModeWidth   = 3;
   localparam int StatusWidth = 2;

   localparam logic [ModeWidth-1:0] MODE_REPORT     = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_PUSH_BACK  = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_POP_BACK   = 3'd4;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_POP_EMPTY  = 2'd1,
      STATUS_PUSH_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic       pop_front;
      logic       pop_back;
      status_type status;
   } outcome_type;

endpackage

>>> design/deq_store.sv
`timescale 1ns / 1ps

module deq_store #(
   parameter int DEPTH      = deq_pkg::DepthDefault,
   parameter int DATA_WIDTH = deq_pkg::DataWidthDefault,
   parameter int PTR_W      = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [PTR_W-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [PTR_W-1:0]      front_addr,
   input  logic [PTR_W-1:0]      back_addr,
   output logic [DATA_WIDTH-1:0] front_data,
   output logic [DATA_WIDTH-1:0] back_data
);

   logic [DATA_WIDTH-1:0] ring_ff [DEPTH];
   logic [DATA_WIDTH-1:0] front_data_ff;
   logic [DATA_WIDTH-1:0] back_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
   end

   // read ahead at the next front and back slots, bypass a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == front_addr)) begin
         front_data_ff <= wr_data;
      end else begin
         front_data_ff <= ring_ff[front_addr];
      end
      if (wr_en && (wr_addr == back_addr)) begin
         back_data_ff <= wr_data;
      end else begin
         back_data_ff <= ring_ff[back_addr];
      end
   end

   assign front_data = front_data_ff;
   assign back_data  = back_data_ff;

endmodule

>>> design/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl #(
   parameter int DEPTH = deq_pkg::DepthDefault,
   parameter int PTR_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          op_valid,
   input  logic [deq_pkg::ModeWidth-1:0] op_mode,
   output logic                          wr_en,
   output logic [PTR_W-1:0]              wr_addr,
   output logic [PTR_W-1:0]              front_addr,
   output logic [PTR_W-1:0]              back_addr,
   output logic [CNT_W-1:0]              count,
   output deq_pkg::outcome_type          outcome
);

   logic [PTR_W-1:0] front_ff;
   logic [PTR_W-1:0] front_in;
   logic [PTR_W-1:0] rear_ff;
   logic [PTR_W-1:0] rear_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             full;
   logic             empty;

   function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      front_in          = front_ff;
      rear_in           = rear_ff;
      count_in          = count_ff;
      wr_en             = 1'b0;
      wr_addr           = rear_ff;
      outcome.pop_front = 1'b0;
      outcome.pop_back  = 1'b0;
      outcome.status    = deq_pkg::STATUS_OK;
      if (op_valid) begin
         unique case (op_mode)
            deq_pkg::MODE_PUSH_FRONT: begin
               if (full) begin
                  outcome.status = deq_pkg::STATUS_PUSH_FULL;
               end else begin
                  front_in = ring_dec(front_ff);
                  wr_en    = 1'b1;
                  wr_addr  = ring_dec(front_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::MODE_PUSH_BACK: begin
               if (full) begin
                  outcome.status = deq_pkg::STATUS_PUSH_FULL;
               end else begin
                  rear_in  = ring_inc(rear_ff);
                  wr_en    = 1'b1;
                  wr_addr  = rear_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::MODE_POP_FRONT: begin
               if (empty) begin
                  outcome.status = deq_pkg::STATUS_POP_EMPTY;
               end else begin
                  outcome.pop_front = 1'b1;
                  front_in          = ring_inc(front_ff);
                  count_in          = count_ff - 1'b1;
               end
            end
            deq_pkg::MODE_POP_BACK: begin
               if (empty) begin
                  outcome.status = deq_pkg::STATUS_POP_EMPTY;
               end else begin
                  outcome.pop_back = 1'b1;
                  rear_in          = ring_dec(rear_ff);
                  count_in         = count_ff - 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   assign front_addr = front_in;
   assign back_addr  = ring_dec(rear_in);
   assign count      = count_ff;

endmodule

>>> design/double_ended_queue_top.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of data words held in a ring of DEPTH entries.
// Request channel: start with req_mode and req_value; a request is taken at
// each rising edge with start high and busy low. busy stays low, so a request
// may be issued in every cycle.
// req_mode: report only, push front, push back, pop front, pop back; codes
// five to seven act as report only.
// Response channel: rsp_valid is high for one cycle per request with the
// popped word, the status (ok, pop on empty, push on full), the empty flag,
// the entry count and the front and back words, which read zero when empty.
// A request is registered in req_valid_ff, then in rsp_valid_ff, the strobe.
// Throughput: one request per cycle; the two read ports of the ring fetch
// the next front and back words alongside each pointer update.
// Reset empties the queue and drops any request in flight; ring contents are
// not cleared. The receiver cannot stall, so each response is taken in its
// strobe cycle.
module double_ended_queue_top #(
   parameter int DEPTH      = deq_pkg::DepthDefault,
   parameter int DATA_WIDTH = deq_pkg::DataWidthDefault,
   parameter int PTR_W      = $clog2(DEPTH),
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [deq_pkg::ModeWidth-1:0]   req_mode,
   input  logic [DATA_WIDTH-1:0]           req_value,
   output logic                            rsp_valid,
   output logic [DATA_WIDTH-1:0]           rsp_popped_value,
   output logic [deq_pkg::StatusWidth-1:0] rsp_status,
   output logic                            rsp_is_empty,
   output logic [CNT_W-1:0]                rsp_entry_count,
   output logic [DATA_WIDTH-1:0]           rsp_front_value,
   output logic [DATA_WIDTH-1:0]           rsp_back_value
);

   logic                          req_valid_ff;
   logic [deq_pkg::ModeWidth-1:0] req_mode_ff;
   logic [DATA_WIDTH-1:0]         req_value_ff;

   logic                          rsp_valid_ff;
   logic [DATA_WIDTH-1:0]         rsp_popped_ff;
   logic [DATA_WIDTH-1:0]         rsp_popped_in;
   deq_pkg::status_type           rsp_status_ff;

   logic                          wr_en;
   logic [PTR_W-1:0]              wr_addr;
   logic [PTR_W-1:0]              front_addr;
   logic [PTR_W-1:0]              back_addr;
   logic [DATA_WIDTH-1:0]         front_data;
   logic [DATA_WIDTH-1:0]         back_data;
   logic [CNT_W-1:0]              count;
   deq_pkg::outcome_type          outcome;
   logic                          empty;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_mode_ff  <= req_mode;
         req_value_ff <= req_value;
      end
   end

   deq_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (req_valid_ff),
      .op_mode    (req_mode_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .front_addr (front_addr),
      .back_addr  (back_addr),
      .count      (count),
      .outcome    (outcome)
   );

   deq_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .PTR_W      (PTR_W)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (req_value_ff),
      .front_addr (front_addr),
      .back_addr  (back_addr),
      .front_data (front_data),
      .back_data  (back_data)
   );

   always_comb begin
      priority if (outcome.pop_front) begin
         rsp_popped_in = front_data;
      end else if (outcome.pop_back) begin
         rsp_popped_in = back_data;
      end else begin
         rsp_popped_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= outcome.status;
   end

   assign empty            = (count == '0);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_is_empty     = empty;
   assign rsp_entry_count  = count;
   assign rsp_front_value  = empty ? '0 : front_data;
   assign rsp_back_value   = empty ? '0 : back_data;

endmodule
